// ----- rtl/dlm_pkg.sv -----
package dlm_pkg;

   typedef enum logic [3:0] {
      ST_RESET       = 4'd0,
      ST_CLOSED      = 4'd1,
      ST_CLOSING     = 4'd2,
      ST_OPENED      = 4'd3,
      ST_OPENING     = 4'd4,
      ST_TIMEOUT_OPN = 4'd5,
      ST_TIMEOUT_CLS = 4'd6,
      ST_ERROR       = 4'd7,
      ST_MANUAL      = 4'd8
   } state_type;

   typedef enum logic [3:0] {
      EV_NONE         = 4'd0,
      EV_CMD_OPEN     = 4'd1,
      EV_CMD_CLOSE    = 4'd2,
      EV_CMD_TOGGLE   = 4'd3,
      EV_BTN_TOGGLE   = 4'd4,
      EV_CARD         = 4'd5,
      EV_OPEN_FIN     = 4'd6,
      EV_CLOSE_FIN    = 4'd7,
      EV_MOVE_TIMEOUT = 4'd8
   } event_type;

   typedef enum logic [1:0] {
      LIM_NONE  = 2'd0,
      LIM_OPEN  = 2'd1,
      LIM_CLOSE = 2'd2,
      LIM_BOTH  = 2'd3
   } limit_type;

   typedef enum logic [1:0] {
      START_NONE  = 2'd0,
      START_OPEN  = 2'd1,
      START_CLOSE = 2'd2
   } start_type;

   localparam logic [3:0] LED_UNSET = 4'd0;

   typedef struct packed {
      logic [1:0] limit_switches;
      logic [3:0] event_code;
   } req_type;

   typedef struct packed {
      logic [3:0] door_state;
      logic [3:0] led_pattern;
      logic [1:0] motor_start;
      logic       event_rejected;
   } rsp_type;

   typedef struct packed {
      state_type  door_state;
      logic [3:0] led_pattern;
   } ctx_type;

endpackage

// ----- rtl/dlm_step.sv -----
module dlm_step (
   input  dlm_pkg::ctx_type cur_ctx,
   input  dlm_pkg::req_type item,
   output dlm_pkg::ctx_type nxt_ctx,
   output dlm_pkg::rsp_type result
);
   import dlm_pkg::*;

   state_type  s0, s1, s2;
   logic [3:0] led1, led2;
   start_type  st1, st2, st_evt;
   logic       rej;
   logic [1:0] lim;
   logic [3:0] ev;

   assign s0  = cur_ctx.door_state;
   assign lim = item.limit_switches;
   assign ev  = item.event_code;

   // limit stage
   always_comb begin
      s1 = s0;
      if (lim == LIM_BOTH) begin
         s1 = ST_ERROR;
      end else if (s0 != ST_CLOSING && s0 != ST_OPENING) begin
         case (lim)
            LIM_OPEN:  s1 = ST_OPENED;
            LIM_CLOSE: s1 = ST_CLOSED;
            default: begin
               case (s0)
                  ST_RESET:  s1 = ST_CLOSING;
                  ST_ERROR,
                  ST_CLOSED,
                  ST_OPENED: s1 = ST_MANUAL;
                  default:   s1 = s0;
               endcase
            end
         endcase
      end
   end

   assign led1 = (s1 != s0) ? s1 : cur_ctx.led_pattern;
   assign st1  = (s1 != s0 && s1 == ST_CLOSING) ? START_CLOSE :
                 (s1 != s0 && s1 == ST_OPENING) ? START_OPEN  : START_NONE;

   // event stage
   always_comb begin
      s2  = s1;
      rej = (ev != EV_NONE);
      case (s1)
         ST_CLOSING,
         ST_OPENING: begin
            case (ev)
               EV_NONE:         rej = 1'b0;
               EV_OPEN_FIN: begin
                  s2  = ST_OPENED;
                  rej = 1'b0;
               end
               EV_CLOSE_FIN: begin
                  s2  = ST_CLOSED;
                  rej = 1'b0;
               end
               EV_MOVE_TIMEOUT: begin
                  s2  = (s1 == ST_OPENING) ? ST_TIMEOUT_OPN : ST_TIMEOUT_CLS;
                  rej = 1'b0;
               end
               default:         rej = 1'b1;
            endcase
         end
         ST_CLOSED,
         ST_OPENED,
         ST_MANUAL,
         ST_TIMEOUT_OPN,
         ST_TIMEOUT_CLS: begin
            case (ev)
               EV_NONE:      rej = 1'b0;
               EV_CMD_OPEN: begin
                  s2  = ST_OPENING;
                  rej = 1'b0;
               end
               EV_CMD_CLOSE: begin
                  s2  = ST_CLOSING;
                  rej = 1'b0;
               end
               EV_CMD_TOGGLE,
               EV_BTN_TOGGLE,
               EV_CARD: begin
                  s2  = (s1 == ST_CLOSED || s1 == ST_TIMEOUT_CLS) ? ST_OPENING : ST_CLOSING;
                  rej = 1'b0;
               end
               default:      rej = 1'b1;
            endcase
         end
         default: rej = (ev != EV_NONE);
      endcase
   end

   assign led2   = (s2 != s1) ? s2 : led1;
   assign st_evt = (s2 != s1 && s2 == ST_CLOSING) ? START_CLOSE :
                   (s2 != s1 && s2 == ST_OPENING) ? START_OPEN  : START_NONE;
   assign st2    = (st_evt != START_NONE) ? st_evt : st1;

   assign nxt_ctx.door_state  = s2;
   assign nxt_ctx.led_pattern = led2;

   assign result.door_state     = s2;
   assign result.led_pattern    = led2;
   assign result.motor_start    = st2;
   assign result.event_rejected = rej;

endmodule

// ----- rtl/door_lock_motion_fsm.sv -----
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | limit_switches, event_code
// rsp     | out       | rsp_valid/rsp_stall | door_state, led_pattern, motor_start,
//         |           |                     | event_rejected
//
// One item per cycle sustained while rsp_stall is low; the path runs from the input
// register through the limit and event transition logic into the result register.
// Synchronous active-high reset: state to reset, LED pattern unset, both stages empty.
// rsp_stall holds the result register and, once the input register is full, stalls req.
module door_lock_motion_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dlm_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dlm_pkg::rsp_type rsp_item
);
   import dlm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;
   ctx_type ctx_ff, ctx_in;
   rsp_type step_rsp;
   logic    adv, req_take;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   dlm_step u_step (
      .cur_ctx (ctx_ff),
      .item    (in_item_ff),
      .nxt_ctx (ctx_in),
      .result  (step_rsp)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (adv ? 1'b0 : in_valid_ff);
      rsp_valid_in = (in_valid_ff && adv) ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         ctx_ff.door_state      <= ST_RESET;
         ctx_ff.led_pattern     <= LED_UNSET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_valid_ff && adv) begin
            ctx_ff <= ctx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_item;
      end
      if (in_valid_ff && adv) begin
         rsp_item_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_no_reset_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.door_state != ST_RESET)
      else $error("result reports reset state");

   a_led_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.led_pattern == rsp_item.door_state)
      else $error("led pattern out of step with state");

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && $stable(in_item_ff) && $stable(ctx_ff))
      else $error("input register lost a stalled item");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("req stalled with room in the pipeline");

endmodule
